FILE: rtl/ceq_pkg.sv
// Shared types and constants for the coalescing event queue.
`default_nettype none
package ceq_pkg;

    localparam int TYPE_W           = 4;
    localparam int NUM_TYPES        = 1 << TYPE_W;
    localparam int MASK_W           = NUM_TYPES;
    localparam logic [MASK_W-1:0] MASK_RESET = 16'd14;
    localparam int QUEUE_DEPTH_DEF  = 256;
    localparam int PAYLOAD_BITS_DEF = 64;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POLL = 1'b1
    } op_t;

    // Row-wide commands broadcast to every cell.
    typedef struct packed {
        logic shift;   // every cell below the top takes its upper neighbor
        logic app;     // write a new entry at the append slot
        logic coal;    // overwrite payload of the newest same-type entry
    } ceq_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/ceq_if.sv
// Valid/ready channel interfaces for requests and poll responses.
`default_nettype none
interface ceq_req_if #(
    parameter int PAYLOAD_BITS = ceq_pkg::PAYLOAD_BITS_DEF
);
    import ceq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    operation;
    logic [TYPE_W-1:0]       event_type;
    logic [PAYLOAD_BITS-1:0] event_payload;

    modport source (output valid, operation, event_type, event_payload, input ready);
    modport sink   (input valid, operation, event_type, event_payload, output ready);
endinterface

interface ceq_rsp_if #(
    parameter int PAYLOAD_BITS = ceq_pkg::PAYLOAD_BITS_DEF
);
    import ceq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    event_valid;
    logic [TYPE_W-1:0]       out_type;
    logic [PAYLOAD_BITS-1:0] out_payload;

    modport source (output valid, event_valid, out_type, out_payload, input ready);
    modport sink   (input valid, event_valid, out_type, out_payload, output ready);
endinterface
`default_nettype wire

FILE: rtl/ceq_cell.sv
// One queue slot: type, payload and newest-of-its-type flag.
`default_nettype none
module ceq_cell #(
    parameter int QUEUE_DEPTH  = ceq_pkg::QUEUE_DEPTH_DEF,
    parameter int PAYLOAD_BITS = ceq_pkg::PAYLOAD_BITS_DEF,
    parameter int IDX          = 0
) (
    input  wire logic                               clk,
    input  wire ceq_pkg::ceq_ctl_t                  ctl,
    input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]   count,
    input  wire logic [$clog2(QUEUE_DEPTH)-1:0]     app_pos,
    input  wire logic [ceq_pkg::TYPE_W-1:0]         wr_type,
    input  wire logic [PAYLOAD_BITS-1:0]            wr_payload,
    input  wire logic [ceq_pkg::TYPE_W-1:0]         nbr_type,
    input  wire logic [PAYLOAD_BITS-1:0]            nbr_payload,
    input  wire logic                               nbr_newest,
    output logic [ceq_pkg::TYPE_W-1:0]              cell_type,
    output logic [PAYLOAD_BITS-1:0]                 cell_payload,
    output logic                                    cell_newest
);
    import ceq_pkg::*;

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [TYPE_W-1:0]       type_reg, type_next, base_type;
    logic [PAYLOAD_BITS-1:0] payload_reg, payload_next, base_payload;
    logic                    newest_reg, newest_next, base_newest;
    logic                    live;

    assign live = (CW'(IDX) < count);

    always_comb
    begin
        base_type    = ctl.shift ? nbr_type    : type_reg;
        base_payload = ctl.shift ? nbr_payload : payload_reg;
        base_newest  = ctl.shift ? nbr_newest  : newest_reg;
        type_next    = base_type;
        payload_next = base_payload;
        newest_next  = base_newest;
        if (ctl.app && (IW'(IDX) == app_pos))
        begin
            type_next    = wr_type;
            payload_next = wr_payload;
            newest_next  = 1'b1;
        end
        else if (ctl.app && (base_type == wr_type))
        begin
            // an older entry of the appended type loses its newest mark
            newest_next = 1'b0;
        end
        if (ctl.coal && live && newest_reg && (type_reg == wr_type))
        begin
            payload_next = wr_payload;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg    <= type_next;
        payload_reg <= payload_next;
        newest_reg  <= newest_next;
    end

    assign cell_type    = type_reg;
    assign cell_payload = payload_reg;
    assign cell_newest  = newest_reg;

endmodule
`default_nettype wire

FILE: rtl/ceq_chain.sv
// Row of queue cells; cell 0 holds the oldest entry.
`default_nettype none
module ceq_chain #(
    parameter int QUEUE_DEPTH  = ceq_pkg::QUEUE_DEPTH_DEF,
    parameter int PAYLOAD_BITS = ceq_pkg::PAYLOAD_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire ceq_pkg::ceq_ctl_t                  ctl,
    input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]   count,
    input  wire logic [$clog2(QUEUE_DEPTH)-1:0]     app_pos,
    input  wire logic [ceq_pkg::TYPE_W-1:0]         wr_type,
    input  wire logic [PAYLOAD_BITS-1:0]            wr_payload,
    output logic [ceq_pkg::TYPE_W-1:0]              head_type,
    output logic [PAYLOAD_BITS-1:0]                 head_payload,
    output logic                                    head_newest
);
    import ceq_pkg::*;

    logic [TYPE_W-1:0]       c_type    [QUEUE_DEPTH];
    logic [PAYLOAD_BITS-1:0] c_payload [QUEUE_DEPTH];
    logic                    c_newest  [QUEUE_DEPTH];

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic [TYPE_W-1:0]       n_type;
        logic [PAYLOAD_BITS-1:0] n_payload;
        logic                    n_newest;

        if (i == QUEUE_DEPTH - 1)
        begin : g_top
            // top cell shifts in nothing; it is dead or rewritten after a shift
            assign n_type    = c_type[i];
            assign n_payload = c_payload[i];
            assign n_newest  = c_newest[i];
        end
        else
        begin : g_mid
            assign n_type    = c_type[i+1];
            assign n_payload = c_payload[i+1];
            assign n_newest  = c_newest[i+1];
        end

        ceq_cell #(
            .QUEUE_DEPTH  (QUEUE_DEPTH),
            .PAYLOAD_BITS (PAYLOAD_BITS),
            .IDX          (i)
        ) u_cell (
            .clk          (clk),
            .ctl          (ctl),
            .count        (count),
            .app_pos      (app_pos),
            .wr_type      (wr_type),
            .wr_payload   (wr_payload),
            .nbr_type     (n_type),
            .nbr_payload  (n_payload),
            .nbr_newest   (n_newest),
            .cell_type    (c_type[i]),
            .cell_payload (c_payload[i]),
            .cell_newest  (c_newest[i])
        );
    end

    assign head_type    = c_type[0];
    assign head_payload = c_payload[0];
    assign head_newest  = c_newest[0];

endmodule
`default_nettype wire

FILE: rtl/coalescing_event_queue.sv
// Top level: coalescing event FIFO with drop-oldest on overflow.
//
//   Channel   Dir   Handshake      Payload
//   req       in    valid/ready    operation, event_type, event_payload
//   rsp       out   valid/ready    event_valid, out_type, out_payload
//   cfg       in    cfg_we         cfg_wdata (coalesce mask)
//
// A request beat is captured in S_IDLE; in S_EXEC the cell row then shifts,
// appends or overwrites in place, and a new beat is taken only back in S_IDLE.
// A poll waits in S_EXEC while the previous response beat is not yet taken. Reset clears the entry
// count and the per-type presence flags; cells need no clearing pass.
`default_nettype none
module coalescing_event_queue #(
    parameter int QUEUE_DEPTH  = ceq_pkg::QUEUE_DEPTH_DEF,
    parameter int PAYLOAD_BITS = ceq_pkg::PAYLOAD_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    ceq_req_if.sink                          req,
    ceq_rsp_if.source                        rsp,
    input  wire logic                        cfg_we,
    input  wire logic [ceq_pkg::MASK_W-1:0]  cfg_wdata
);
    import ceq_pkg::*;

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                  state_reg, state_next;
    op_t                     op_reg, op_next;
    logic [TYPE_W-1:0]       typ_reg, typ_next;
    logic [PAYLOAD_BITS-1:0] pay_reg, pay_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [NUM_TYPES-1:0]    has_reg, has_next;
    logic [MASK_W-1:0]       mask_reg, mask_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    ev_valid_reg, ev_valid_next;
    logic [TYPE_W-1:0]       out_type_reg, out_type_next;
    logic [PAYLOAD_BITS-1:0] out_pay_reg, out_pay_next;

    ceq_ctl_t                ctl;
    logic [IW-1:0]           app_pos;
    logic [TYPE_W-1:0]       head_type;
    logic [PAYLOAD_BITS-1:0] head_payload;
    logic                    head_newest;

    ceq_chain #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_chain (
        .clk          (clk),
        .ctl          (ctl),
        .count        (count_reg),
        .app_pos      (app_pos),
        .wr_type      (typ_reg),
        .wr_payload   (pay_reg),
        .head_type    (head_type),
        .head_payload (head_payload),
        .head_newest  (head_newest)
    );

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        typ_next       = typ_reg;
        pay_next       = pay_reg;
        count_next     = count_reg;
        has_next       = has_reg;
        mask_next      = cfg_we ? cfg_wdata : mask_reg;
        out_valid_next = out_valid_reg;
        ev_valid_next  = ev_valid_reg;
        out_type_next  = out_type_reg;
        out_pay_next   = out_pay_reg;
        ctl            = '0;
        app_pos        = '0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = op_t'(req.operation);
                    typ_next   = req.event_type;
                    pay_next   = req.event_payload;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (op_reg == OP_POLL)
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                        if (count_reg != '0)
                        begin
                            ev_valid_next = 1'b1;
                            out_type_next = head_type;
                            out_pay_next  = head_payload;
                            ctl.shift     = 1'b1;
                            count_next    = count_reg - CW'(1);
                            if (head_newest)
                            begin
                                has_next[head_type] = 1'b0;
                            end
                        end
                        else
                        begin
                            ev_valid_next = 1'b0;
                            out_type_next = '0;
                            out_pay_next  = '0;
                        end
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                    if (mask_reg[typ_reg] && has_reg[typ_reg])
                    begin
                        ctl.coal = 1'b1;
                    end
                    else
                    begin
                        ctl.app = 1'b1;
                        if (count_reg == CW'(QUEUE_DEPTH))
                        begin
                            // full: drop the oldest, append at the top cell
                            ctl.shift = 1'b1;
                            app_pos   = IW'(QUEUE_DEPTH - 1);
                            if (head_newest)
                            begin
                                has_next[head_type] = 1'b0;
                            end
                        end
                        else
                        begin
                            app_pos    = count_reg[IW-1:0];
                            count_next = count_reg + CW'(1);
                        end
                        has_next[typ_reg] = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_PUSH;
            typ_reg       <= '0;
            pay_reg       <= '0;
            count_reg     <= '0;
            has_reg       <= '0;
            mask_reg      <= MASK_RESET;
            out_valid_reg <= 1'b0;
            ev_valid_reg  <= 1'b0;
            out_type_reg  <= '0;
            out_pay_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            typ_reg       <= typ_next;
            pay_reg       <= pay_next;
            count_reg     <= count_next;
            has_reg       <= has_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
            ev_valid_reg  <= ev_valid_next;
            out_type_reg  <= out_type_next;
            out_pay_reg   <= out_pay_next;
        end
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.event_valid = ev_valid_reg;
    assign rsp.out_type    = out_type_reg;
    assign rsp.out_payload = out_pay_reg;

endmodule
`default_nettype wire

FILE: rtl/ceq_checker.sv
// Port-level checks for the coalescing event queue, bound to the top level.
`default_nettype none
module ceq_checker #(
    parameter int PAYLOAD_BITS = ceq_pkg::PAYLOAD_BITS_DEF
) (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         req_valid,
    input wire logic                         req_ready,
    input wire logic                         req_operation,
    input wire logic                         rsp_valid,
    input wire logic                         rsp_ready,
    input wire logic                         rsp_event_valid,
    input wire logic [ceq_pkg::TYPE_W-1:0]   rsp_out_type,
    input wire logic [PAYLOAD_BITS-1:0]      rsp_out_payload
);
    import ceq_pkg::*;

    // a stalled response beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_payload)
            && $stable(rsp_out_type) && $stable(rsp_event_valid))
        else $error("response beat changed while stalled");

    // an empty poll reports type none and zero payload
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_event_valid |-> rsp_out_type == '0 && rsp_out_payload == '0)
        else $error("empty poll carries data");

    // a request is never accepted right behind another
    a_req_gap: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted in back-to-back cycles");

    // a new response rises only after an accepted poll beat
    a_rsp_from_poll: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready && (req_operation == OP_POLL), 2))
        else $error("response without a poll");

endmodule

bind coalescing_event_queue ceq_checker #(
    .PAYLOAD_BITS (PAYLOAD_BITS)
) u_ceq_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .req_operation   (req.operation),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_event_valid (rsp.event_valid),
    .rsp_out_type    (rsp.out_type),
    .rsp_out_payload (rsp.out_payload)
);
`default_nettype wire

FILE: verif/tb_coalescing_event_queue.sv
// Self-checking testbench for the coalescing event queue: directed, overflow, pause and random traffic.
module tb_coalescing_event_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import ceq_pkg::*;

    localparam int DEPTH       = QUEUE_DEPTH_DEF;
    localparam int PBITS       = PAYLOAD_BITS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 8;

    typedef struct {
        logic              found;
        logic [TYPE_W-1:0] kind;
        logic [PBITS-1:0]  data;
    } poll_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [MASK_W-1:0] cfg_wdata;

    ceq_req_if req ();
    ceq_rsp_if rsp ();

    coalescing_event_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // queue state as predicted from the accepted beats
    logic [TYPE_W-1:0] slot_kind [DEPTH];
    logic [PBITS-1:0]  slot_data [DEPTH];
    int                head_slot;
    int                live_count;
    logic [MASK_W-1:0] coalesce_bits;

    poll_result_t expected_polls[$];
    int           error_count;
    int           cycle_count;
    int           sender_idle_pct;
    int           receiver_stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_coalescing_event_queue: done, errors");
        $finish;
    end

    // receiver: randomly stall the response channel
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rsp.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    function automatic void merge_or_append(logic [TYPE_W-1:0] kind, logic [PBITS-1:0] data);
        int  k;
        int  slot;
        bit  merged;
        merged = 1'b0;
        if (coalesce_bits[kind])
        begin
            // newest matching entry wins
            for (k = live_count - 1; k >= 0 && !merged; k--)
            begin
                slot = (head_slot + k) % DEPTH;
                if (slot_kind[slot] == kind)
                begin
                    slot_data[slot] = data;
                    merged = 1'b1;
                end
            end
        end
        if (!merged)
        begin
            if (live_count >= DEPTH)
            begin
                // drop oldest to make room
                head_slot  = (head_slot + 1) % DEPTH;
                live_count = DEPTH - 1;
            end
            slot = (head_slot + live_count) % DEPTH;
            slot_kind[slot] = kind;
            slot_data[slot] = data;
            live_count++;
        end
    endfunction

    function automatic poll_result_t pop_oldest();
        poll_result_t r;
        r.found = 1'b0;
        r.kind  = '0;
        r.data  = '0;
        if (live_count != 0)
        begin
            r.found    = 1'b1;
            r.kind     = slot_kind[head_slot];
            r.data     = slot_data[head_slot];
            head_slot  = (head_slot + 1) % DEPTH;
            live_count--;
        end
        return r;
    endfunction

    function automatic void check_response();
        poll_result_t want;
        if (expected_polls.size() == 0)
        begin
            $display("%0t: unexpected response, expected none, actual valid=%0b type=%0d data=%h",
                     $time, rsp.event_valid, rsp.out_type, rsp.out_payload);
            error_count++;
        end
        else
        begin
            want = expected_polls[0];
            expected_polls.delete(0);
            if (rsp.event_valid !== want.found)
            begin
                $display("%0t: event_valid expected %0b actual %0b",
                         $time, want.found, rsp.event_valid);
                error_count++;
            end
            if (rsp.out_type !== want.kind)
            begin
                $display("%0t: out_type expected %0d actual %0d", $time, want.kind, rsp.out_type);
                error_count++;
            end
            if (rsp.out_payload !== want.data)
            begin
                $display("%0t: out_payload expected %h actual %h",
                         $time, want.data, rsp.out_payload);
                error_count++;
            end
        end
    endfunction

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1)
                check_response();
        end
    end

    // drive one request beat, hold it until taken, then maybe idle
    task automatic send_item(op_t op, logic [TYPE_W-1:0] kind, logic [PBITS-1:0] data);
        req.valid         <= 1'b1;
        req.operation     <= op;
        req.event_type    <= kind;
        req.event_payload <= data;
        @(posedge clk);
        while (req.ready !== 1'b1)
            @(posedge clk);
        if (op == OP_PUSH)
            merge_or_append(kind, data);
        else
            expected_polls.insert(expected_polls.size(), pop_oldest());
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct)
                @(posedge clk);
        end
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (expected_polls.size() != 0)
            @(posedge clk);
        // pushes give no response; let the last one finish
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_mask(logic [MASK_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        coalesce_bits = value;
        cfg_we <= 1'b0;
    endtask

    function automatic logic [TYPE_W-1:0] pick_kind();
        if ($urandom_range(99) < 60)
            return TYPE_W'($urandom_range(1, 4));
        return TYPE_W'($urandom_range(0, NUM_TYPES - 1));
    endfunction

    function automatic logic [PBITS-1:0] pick_data();
        return {$urandom, $urandom};
    endfunction

    task automatic push_item(logic [TYPE_W-1:0] kind, logic [PBITS-1:0] data);
        send_item(OP_PUSH, kind, data);
    endtask

    task automatic poll_item();
        send_item(OP_POLL, pick_kind(), pick_data());
    endtask

    task automatic test_directed();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        poll_item();                                   // empty queue
        push_item(4'd0, '0);
        push_item(4'd15, '1);
        push_item(4'd1, 64'h0000_0000_0000_0011);
        push_item(4'd1, 64'h0000_0000_0000_0022);      // redraw merges
        push_item(4'd4, 64'hA5A5_A5A5_5A5A_5A5A);
        push_item(4'd4, 64'h5A5A_5A5A_A5A5_A5A5);      // mode change appends
        push_item(4'd3, 64'h8000_0000_0000_0001);
        send_item(OP_POLL, 4'd15, '1);
        repeat (5) poll_item();
        poll_item();                                   // empty again
        write_mask('1);
        push_item(4'd0, 64'h1);
        push_item(4'd15, 64'h2);
        push_item(4'd0, 64'h3);                        // type zero merges
        push_item(4'd15, '1);
        repeat (3) poll_item();
        write_mask('0);
        push_item(4'd2, 64'h7);
        push_item(4'd2, 64'h8);                        // no merge with mask clear
        repeat (2) poll_item();
    endtask

    task automatic test_overflow();
        int i;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        write_mask('0);
        for (i = 0; i < DEPTH + 34; i++)
            push_item(TYPE_W'($urandom_range(0, NUM_TYPES - 1)), pick_data());
        // full queue: merges must not drop, plain appends must
        write_mask(MASK_RESET);
        for (i = 0; i < 10; i++)
            push_item(pick_kind(), pick_data());
        for (i = 0; i < DEPTH + 6; i++)
            poll_item();
    endtask

    task automatic test_pause();
        int i;
        sender_idle_pct    = 25;
        receiver_stall_pct = 25;
        for (i = 0; i < 10; i++)
            push_item(pick_kind(), pick_data());
        repeat (6) poll_item();
        // hold off until every response is back
        req.valid <= 1'b0;
        @(posedge clk);
        while (expected_polls.size() != 0)
            @(posedge clk);
        repeat (6) poll_item();
    endtask

    task automatic run_random_phase(int items, int idle_pct, int stall_pct, int push_pct);
        int i;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (i = 0; i < items; i++)
        begin
            if ($urandom_range(99) < push_pct)
                push_item(pick_kind(), pick_data());
            else
                poll_item();
        end
    endtask

    task automatic test_random();
        write_mask(MASK_RESET);
        run_random_phase(120, 0, 0, 55);
        write_mask('1);
        run_random_phase(120, 76, 0, 60);
        write_mask(MASK_W'($urandom_range(0, 65535)));
        run_random_phase(120, 0, 76, 50);
        write_mask('0);
        run_random_phase(120, 25, 25, 55);
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        req.valid         = 1'b0;
        req.operation     = OP_PUSH;
        req.event_type    = '0;
        req.event_payload = '0;
        error_count        = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        head_slot          = 0;
        live_count         = 0;
        coalesce_bits      = MASK_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_overflow();
        test_pause();
        test_random();

        drain();
        if (error_count == 0)
            $display("tb_coalescing_event_queue: done, clean");
        else
            $display("tb_coalescing_event_queue: done, errors");
        $finish;
    end

endmodule
